### rtl/shaker_pkg.sv
// Package for the bead-collision shaker synthesizer.
// Holds the transaction mode codes, register indexes, fixed constants and the saturation helper.
// No dependencies.
package shaker_pkg;

  // Transaction modes
  localparam logic [1:0] ModeTick  = 2'd0;
  localparam logic [1:0] ModeShake = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] RegThreshold = 3'd0;
  localparam logic [2:0] RegGain      = 3'd1;
  localparam logic [2:0] RegCoeff     = 3'd2;
  localparam logic [2:0] RegSysDecay  = 3'd3;
  localparam logic [2:0] RegSndDecay  = 3'd4;

  // Register reset values
  localparam logic [10:0]        ThresholdRst = 11'd512;
  localparam logic [22:0]        GainRst      = 23'd69120;
  localparam logic signed [17:0] CoeffRst     = -18'sd83497;
  localparam logic [16:0]        SysDecayRst  = 17'd65339;
  localparam logic [16:0]        SndDecayRst  = 17'd62259;

  // Fixed arithmetic constants
  localparam logic [16:0]        EnergyOne   = 17'd65536;
  localparam logic signed [17:0] CoeffTwo    = 18'sd32113;  // 0.49 in Q.16
  localparam logic [15:0]        NoiseCenter = 16'd16384;

  // Shared multiplier: 32-bit signed by 18-bit signed
  localparam int MulAW = 32;
  localparam int MulBW = 18;
  localparam int ProdW = MulAW + MulBW;
  localparam int AccW  = 40;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] x);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &x[ProdW-1:31];
    hi_zeros = ~|x[ProdW-1:31];
    if (hi_ones || hi_zeros) begin
      sat32 = x[31:0];
    end else if (x[ProdW-1]) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = 32'sh7fff_ffff;
    end
  endfunction

endpackage

### rtl/shaker_collision_synth.sv
// Top level of the bead-collision shaker synthesizer.
// Holds the register file, the sequencer and the shared multiplier; uses shaker_pkg.
//
// Usage:
// - Input channel (in_valid_i / in_ready_o) carries one transaction per item: a tick
//   (mode 0) that produces one sample, a shake (mode 1) that adds energy, or a clear
//   (mode 2) that zeros the resonator history. Mode 3 is accepted and ignored.
// - Output channel (out_valid_o / out_ready_i) carries one sample per tick.
// - Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i);
//   it must only be written while no tick is in flight.
// Operation:
// - A tick walks a sequencer through six multiply steps on one shared 32x18 signed
//   multiplier, one step that stores the new level and resonator output, and one step
//   that forms the sample; the block takes no new transaction until the tick is done.
// - Shake, clear and unused modes complete in the accept cycle; the block is ready
//   again in the next cycle.
// - The sample sits in an output register, so the next transaction is accepted while
//   a sample still waits. If the receiver stalls and a further tick finishes, that tick
//   holds in its last step until the waiting sample is taken.
// Reset clears the shake energy, sound level, resonator history and output valid, and
// loads the default register values.
module shaker_collision_synth #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input transactions
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [9:0]         collision_draw_i,
  input  logic [14:0]        noise_draw_i,
  input  logic [16:0]        shake_amount_i,
  // Output samples
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] sample_o,
  // Configuration writes
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [22:0]        cfg_wdata_i
);
  import shaker_pkg::*;

  // The collision term gain*energy is Q.32 and moves to Q.FRAC_BITS.
  localparam int GainShift = 32 - FRAC_BITS;

  // Sequencer steps. S_ENERGY to S_LEVEL each issue one multiply; S_RES1 to S_OUT each consume the previous product.
  typedef enum logic [3:0] {
    S_IDLE,    // wait for a transaction
    S_ENERGY,  // energy * system decay
    S_RES1,    // store energy; last * coeff
    S_GAIN,    // start accumulator; gain * energy
    S_RES2,    // add collision to level; prior * 0.49
    S_NOISE,   // accumulate; level * noise
    S_LEVEL,   // accumulate; level * sound decay
    S_OUT,     // store level, saturate new resonator output
    S_DIFF     // form the sample once the output register is free
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [10:0]        threshold_q;
  logic [22:0]        gain_q;
  logic signed [17:0] coeff_q;
  logic [16:0]        sys_decay_q;
  logic [16:0]        snd_decay_q;

  // Synthesis state
  logic [16:0]        energy_q;
  logic signed [31:0] level_q;
  logic signed [31:0] last_q;
  logic signed [31:0] prior_q;

  // Per-tick working registers
  logic                   collide_q;
  logic signed [15:0]     noise_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;

  // Output register
  logic               out_valid_q;
  logic signed [31:0] sample_q;

  // Shared multiplier operand selection
  logic signed [MulAW-1:0] op_a;
  logic signed [MulBW-1:0] op_b;
  logic signed [ProdW-1:0] prod_d;

  always_comb begin
    op_a = level_q;
    op_b = MulBW'(signed'({1'b0, snd_decay_q}));
    case (state_q)
      S_ENERGY: begin
        op_a = MulAW'(signed'({1'b0, energy_q}));
        op_b = MulBW'(signed'({1'b0, sys_decay_q}));
      end
      S_RES1: begin
        op_a = last_q;
        op_b = coeff_q;
      end
      S_GAIN: begin
        op_a = MulAW'(signed'({1'b0, gain_q}));
        op_b = MulBW'(signed'({1'b0, energy_q}));
      end
      S_RES2: begin
        op_a = prior_q;
        op_b = CoeffTwo;
      end
      S_NOISE: begin
        op_a = level_q;
        op_b = MulBW'(noise_q);
      end
      S_LEVEL: begin
        op_a = level_q;
        op_b = MulBW'(signed'({1'b0, snd_decay_q}));
      end
      default: begin
        op_a = level_q;
        op_b = MulBW'(signed'({1'b0, snd_decay_q}));
      end
    endcase
  end

  assign prod_d = op_a * op_b;

  // Helper values derived from the registered product
  logic [17:0]             energy_raw;
  logic [16:0]             energy_new;
  logic signed [33:0]      gain_term;
  logic signed [33:0]      level_sum;
  logic signed [AccW-1:0]  term16;
  logic signed [AccW-1:0]  term14;
  logic signed [32:0]      diff_wide;
  logic                    tick_accept;
  logic                    out_free;

  // Energy is at most 65536 and the decay at most 131071, so prod[33:16] holds it all.
  assign energy_raw = prod_q[33:16];
  assign energy_new = (energy_raw > 18'(EnergyOne)) ? EnergyOne : energy_raw[16:0];
  assign gain_term  = 34'(prod_q >>> GainShift);
  assign level_sum  = 34'(level_q) + gain_term;
  assign term16     = AccW'(prod_q >>> 16);
  assign term14     = AccW'(prod_q >>> 14);
  assign diff_wide  = 33'(last_q) - 33'(prior_q);

  assign in_ready_o  = (state_q == S_IDLE);
  assign tick_accept = in_valid_i && in_ready_o && (mode_i == ModeTick);
  assign out_free    = !out_valid_q || out_ready_i;

  // Configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdRst;
      gain_q      <= GainRst;
      coeff_q     <= CoeffRst;
      sys_decay_q <= SysDecayRst;
      snd_decay_q <= SndDecayRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegThreshold: threshold_q <= cfg_wdata_i[10:0];
        RegGain:      gain_q      <= cfg_wdata_i;
        RegCoeff:     coeff_q     <= signed'(cfg_wdata_i[17:0]);
        RegSysDecay:  sys_decay_q <= cfg_wdata_i[16:0];
        RegSndDecay:  snd_decay_q <= cfg_wdata_i[16:0];
        default: ;
      endcase
    end
  end

  // Per-tick operands and the product register carry no reset.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (tick_accept) begin
      collide_q <= ({1'b0, collision_draw_i} < threshold_q);
      noise_q   <= signed'(16'(noise_draw_i) - NoiseCenter);
    end
  end

  // Sequencer, synthesis state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      energy_q    <= '0;
      level_q     <= '0;
      last_q      <= '0;
      prior_q     <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      sample_q    <= '0;
    end else begin
      // In the last step the valid flag is handled there, together with the new sample.
      if (out_valid_q && out_ready_i && (state_q != S_DIFF)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            case (mode_i)
              ModeTick: state_q <= S_ENERGY;
              ModeShake: begin
                if ((18'(energy_q) + 18'(shake_amount_i)) > 18'(EnergyOne)) begin
                  energy_q <= EnergyOne;
                end else begin
                  energy_q <= energy_q + shake_amount_i;
                end
              end
              ModeClear: begin
                last_q  <= '0;
                prior_q <= '0;
              end
              default: ;
            endcase
          end
        end
        S_ENERGY: state_q <= S_RES1;
        S_RES1: begin
          energy_q <= energy_new;
          state_q  <= S_GAIN;
        end
        S_GAIN: begin
          acc_q   <= -term16;
          state_q <= S_RES2;
        end
        S_RES2: begin
          if (collide_q) begin
            level_q <= sat32(ProdW'(level_sum));
          end
          state_q <= S_NOISE;
        end
        S_NOISE: begin
          acc_q   <= acc_q - term16;
          state_q <= S_LEVEL;
        end
        S_LEVEL: begin
          acc_q   <= acc_q + term14;
          state_q <= S_OUT;
        end
        S_OUT: begin
          level_q <= sat32(prod_q >>> 16);
          prior_q <= last_q;
          last_q  <= sat32(ProdW'(acc_q));
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          if (out_free) begin
            sample_q    <= sat32(ProdW'(diff_wide));
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  // The shake energy never rises above one.
  a_energy_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    energy_q <= EnergyOne)
    else $error("shake energy above one");

  // An accepted tick starts the sequencer.
  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_accept |=> (state_q == S_ENERGY))
    else $error("tick did not start the sequencer");

  // Shake, clear and unused modes finish at once.
  a_other_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (mode_i != ModeTick)) |=> (state_q == S_IDLE))
    else $error("non-tick transaction left the idle state");

  // A finished tick never overwrites a sample still waiting for the receiver.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DIFF) && out_valid_q && !out_ready_i) |=>
      ((state_q == S_DIFF) && $stable(sample_q)))
    else $error("waiting sample overwritten");

endmodule

### test/shaker_collision_synth_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the bead-collision shaker synthesizer: a directed table of
// transactions followed by randomized configuration phases, all checked by a local predictor.
// Depends on shaker_pkg and the shaker_collision_synth RTL.

module shaker_collision_synth_tb;
  import shaker_pkg::*;

  localparam int FracBits    = 16;
  localparam int NoiseShift  = 14;   // centered noise is a Q.14 fraction
  localparam int QuietCycles = 12;   // leave some margin after a tick
  localparam int TailCycles  = 24;
  localparam int IdleLimit   = 400;  // cycles with no handshake before the run is abandoned
  localparam int NumPhases   = 10;
  localparam int PhaseItems  = 80;
  localparam int ReportLimit = 10;

  localparam longint WordMax = 64'sd2147483647;
  localparam longint WordMin = -WordMax - 1;

  // The block accepts mode 3 and discards it, and it ignores writes above the last
  // register index.
  localparam logic [1:0] ModeSpare  = 2'd3;
  localparam logic [2:0] RegBadLow  = 3'd5;
  localparam logic [2:0] RegBadHigh = 3'd7;

  typedef enum int {CfgNominal, CfgHigh, CfgLow, CfgRandom} cfg_style_e;

  // One row of the directed table: either a register write or an input transaction.
  // Where the sample is obvious it is typed into the row instead of being predicted.
  typedef struct packed {
    bit          is_reg;
    logic [2:0]  reg_idx;
    logic [22:0] reg_val;
    logic [1:0]  mode;
    logic [9:0]  draw;
    logic [14:0] noise;
    logic [16:0] amount;
    bit          known;
    logic [31:0] want;
  } stim_row_t;

  // Every input of the block starts from a known value.
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         mode_i = ModeTick;
  logic [9:0]         collision_draw_i = '0;
  logic [14:0]        noise_draw_i = '0;
  logic [16:0]        shake_amount_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b1;
  logic signed [31:0] sample_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_index_i = RegThreshold;
  logic [22:0]        cfg_wdata_i = '0;

  // Predictor copy of the registers and of the synthesizer state.
  logic [10:0]        bead_count;
  logic [22:0]        hit_gain;
  logic signed [17:0] res_coeff;
  logic [16:0]        energy_decay;
  logic [16:0]        level_decay;
  logic [16:0]        energy;
  logic signed [31:0] level;
  logic signed [31:0] res_last;
  logic signed [31:0] res_prior;

  // Samples the block still owes, oldest first.
  logic signed [31:0] sample_q[$];
  stim_row_t          stim_table[$];

  int failures = 0;
  int idle_cycles = 0;
  bit sender_gaps = 1'b1;
  bit sink_stalls = 1'b1;

  shaker_collision_synth #(
    .FRAC_BITS(FracBits)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .collision_draw_i(collision_draw_i),
    .noise_draw_i    (noise_draw_i),
    .shake_amount_i  (shake_amount_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sample_o        (sample_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic signed [31:0] clamp_word(input longint v);
    if (v > WordMax) return WordMax[31:0];
    if (v < WordMin) return WordMin[31:0];
    return v[31:0];
  endfunction

  // Advances the predictor by one transaction. Returns 1 when the transaction yields a
  // sample. All arithmetic is done in 64 bits; >>> on a signed value floors, which is the
  // rounding the block uses for every rescaled product.
  function automatic bit step_model(input logic [1:0] mode, input logic [9:0] draw,
                                    input logic [14:0] noise_raw, input logic [16:0] amount,
                                    output logic signed [31:0] predicted);
    longint e, lvl, last, prior, noise, acc, g, sd, ld, rc, c2, nc, one, add, dr, bc;
    predicted = '0;
    e     = longint'(energy);
    lvl   = longint'(level);
    last  = longint'(res_last);
    prior = longint'(res_prior);
    g     = longint'(hit_gain);
    sd    = longint'(energy_decay);
    ld    = longint'(level_decay);
    rc    = longint'(res_coeff);
    c2    = longint'(CoeffTwo);
    nc    = longint'(NoiseCenter);
    one   = longint'(EnergyOne);
    add   = longint'(amount);
    dr    = longint'(draw);
    bc    = longint'(bead_count);
    noise = longint'(noise_raw);
    noise = noise - nc;
    case (mode)
      ModeShake: begin
        e = e + add;
        if (e > one) e = one;
        energy = e[16:0];
        return 1'b0;
      end
      ModeClear: begin
        res_last  = '0;
        res_prior = '0;
        return 1'b0;
      end
      ModeTick: begin
        // A decay factor above one can push the energy past one; it is capped there.
        e = (e * sd) >> 16;
        if (e > one) e = one;
        energy = e[16:0];
        if (dr < bc) lvl = longint'(clamp_word(lvl + ((g * e) >>> (32 - FracBits))));
        // The excitation uses the level from before this tick's decay.
        acc   = (lvl * noise) >>> NoiseShift;
        lvl   = longint'(clamp_word((lvl * ld) >>> 16));
        level = lvl[31:0];
        acc   = acc - ((last * rc) >>> 16) - ((prior * c2) >>> 16);
        res_prior = res_last;
        res_last  = clamp_word(acc);
        last      = longint'(res_last);
        prior     = longint'(res_prior);
        predicted = clamp_word(last - prior);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic stim_row_t item_row(input logic [1:0] mode, input logic [9:0] draw,
                                         input logic [14:0] noise, input logic [16:0] amount,
                                         input bit known = 1'b0, input logic [31:0] want = '0);
    stim_row_t row;
    row        = '0;
    row.mode   = mode;
    row.draw   = draw;
    row.noise  = noise;
    row.amount = amount;
    row.known  = known;
    row.want   = want;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [2:0] idx, input logic [22:0] value);
    stim_row_t row;
    row         = '0;
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = value;
    return row;
  endfunction

  // Chooses a register value for one configuration phase. Random phases mix the range
  // limits, values past the useful range, and now and then junk in the unused upper bits.
  function automatic logic [22:0] pick_reg_value(input logic [2:0] idx, input cfg_style_e style);
    logic [22:0] v, keep, nom, low_v, high_v, wide, span, junk;
    int          cf;
    keep = '1;
    case (idx)
      RegThreshold: begin
        keep   = 23'h0007ff;
        nom    = 23'(ThresholdRst);
        low_v  = 23'd1;
        high_v = 23'd2047;
        wide   = 23'd0;
        span   = 23'($urandom_range(1, 1024));
      end
      RegGain: begin
        nom    = GainRst;
        low_v  = 23'd0;
        high_v = 23'h7fffff;
        wide   = 23'd7864320;
        span   = 23'($urandom_range(0, 7864320));
      end
      RegCoeff: begin
        keep   = 23'h03ffff;
        nom    = {5'd0, CoeffRst};
        cf     = -91750;
        low_v  = {5'd0, cf[17:0]};
        high_v = 23'h01ffff;
        wide   = 23'h020000;
        cf     = $urandom_range(0, 183500);
        cf     = cf - 91750;
        span   = {5'd0, cf[17:0]};
      end
      RegSysDecay: begin
        keep   = 23'h01ffff;
        nom    = 23'(SysDecayRst);
        low_v  = 23'd0;
        high_v = 23'h01ffff;
        wide   = 23'd65536;
        span   = 23'($urandom_range(63000, 65536));
      end
      RegSndDecay: begin
        keep   = 23'h01ffff;
        nom    = 23'(SndDecayRst);
        low_v  = 23'd0;
        high_v = 23'h01ffff;
        wide   = 23'd65536;
        span   = 23'($urandom_range(50000, 65536));
      end
      default: begin
        nom    = 23'($urandom());
        low_v  = nom;
        high_v = nom;
        wide   = nom;
        span   = nom;
      end
    endcase
    case (style)
      CfgNominal: v = nom;
      CfgHigh:    v = high_v;
      CfgLow:     v = low_v;
      default: begin
        case ($urandom_range(0, 5))
          0:       v = low_v;
          1:       v = high_v;
          2:       v = wide;
          default: v = span;
        endcase
      end
    endcase
    if (style == CfgRandom && $urandom_range(0, 3) == 0) begin
      junk = 23'($urandom());
      v    = v | (junk & ~keep);
    end
    return v;
  endfunction

  // Register writes: the enable is held for one cycle and then dropped before the next
  // write. The predictor copy changes at the same point, which is safe because writes
  // only happen while the block is idle.
  task automatic write_reg(input logic [2:0] idx, input logic [22:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      RegThreshold: bead_count   = value[10:0];
      RegGain:      hit_gain     = value;
      RegCoeff:     res_coeff    = value[17:0];
      RegSysDecay:  energy_decay = value[16:0];
      RegSndDecay:  level_decay  = value[16:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Holds the input side until every owed sample has been taken, then lets the given
  // number of further cycles pass. It never returns in the time step it was called in, so
  // that valid is never dropped and raised again in the same time step.
  task automatic drain_samples(input int quiet);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sample_q.size() != 0);
    repeat (quiet) @(negedge clk_i);
  endtask

  // Presents one input transaction from a falling edge and returns at the falling edge
  // after it was accepted. Valid stays high between back-to-back transactions unless a random gap is put in.
  task automatic send_item(input logic [1:0] mode, input logic [9:0] draw,
                           input logic [14:0] noise, input logic [16:0] amount,
                           input bit known = 1'b0, input logic [31:0] want = '0);
    logic signed [31:0] predicted;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    mode_i           <= mode;
    collision_draw_i <= draw;
    noise_draw_i     <= noise;
    shake_amount_i   <= amount;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (step_model(mode, draw, noise, amount, predicted)) begin
      sample_q.push_back(known ? want : predicted);
    end
    @(negedge clk_i);
  endtask

  task automatic report_failure(input string what, input logic signed [31:0] wanted,
                                input logic signed [31:0] got);
    failures++;
    if (failures <= ReportLimit) begin
      $display("%s: expected %0d, got %0d", what, wanted, got);
    end
  endtask

  // Result checker: every accepted sample is compared with the oldest owed one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sample_q.size() == 0) begin
        report_failure("sample with no tick waiting", 'x, sample_o);
      end else if (sample_o !== sample_q[0]) begin
        report_failure("sample mismatch", sample_q.pop_front(), sample_o);
      end else begin
        void'(sample_q.pop_front());
      end
    end
  end

  // Receiver: ready drops at random while stalls are enabled.
  initial begin
    forever begin
      @(negedge clk_i);
      if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog: any transaction on either channel, or a register write, counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: the directed table first, then randomized phases that each start from a
  // fresh register setting.
  initial begin
    cfg_style_e  style;
    int          pick;
    logic [1:0]  mode;
    logic [16:0] amount;

    bead_count   = ThresholdRst;
    hit_gain     = GainRst;
    res_coeff    = CoeffRst;
    energy_decay = SysDecayRst;
    level_decay  = SndDecayRst;
    energy       = '0;
    level        = '0;
    res_last     = '0;
    res_prior    = '0;

    // From reset the energy is zero, so the first tick is silent. The unused mode must
    // leave everything alone, and a second full shake overshoots the energy cap.
    stim_table.push_back(item_row(ModeTick, 10'd0, 15'd0, 17'd0, 1'b1, 32'd0));
    stim_table.push_back(item_row(ModeSpare, 10'h3ff, 15'h7fff, 17'h1ffff));
    stim_table.push_back(item_row(ModeShake, 10'd0, 15'd0, 17'd65536));
    stim_table.push_back(item_row(ModeShake, 10'h3ff, 15'h7fff, 17'h1ffff));
    stim_table.push_back(item_row(ModeTick, 10'd0, 15'h7fff, 17'd0));
    stim_table.push_back(item_row(ModeTick, 10'h3ff, 15'd0, 17'h1ffff));
    stim_table.push_back(item_row(ModeTick, 10'd511, 15'd16384, 17'd0));
    stim_table.push_back(item_row(ModeTick, 10'd512, 15'd1, 17'd0));
    stim_table.push_back(item_row(ModeClear, 10'h3ff, 15'h7fff, 17'h1ffff));
    stim_table.push_back(item_row(ModeTick, 10'd0, 15'd0, 17'd0));
    // A bead count of zero never collides, and a decay factor above one drives the
    // energy into its cap. Writes past the last register must change nothing.
    stim_table.push_back(reg_row(RegThreshold, 23'd0));
    stim_table.push_back(reg_row(RegSysDecay, 23'h01ffff));
    stim_table.push_back(reg_row(RegBadLow, 23'h7fffff));
    stim_table.push_back(reg_row(RegBadHigh, 23'h7fffff));
    stim_table.push_back(item_row(ModeShake, 10'd0, 15'd0, 17'd65536));
    stim_table.push_back(item_row(ModeTick, 10'd0, 15'h7fff, 17'd0));
    stim_table.push_back(item_row(ModeTick, 10'd0, 15'd0, 17'd0));
    // Full gain, a growing level and the most negative coefficient: the level and the
    // resonator head for their saturation limits.
    stim_table.push_back(reg_row(RegGain, 23'h7fffff));
    stim_table.push_back(reg_row(RegThreshold, 23'd2047));
    stim_table.push_back(reg_row(RegSndDecay, 23'h01ffff));
    stim_table.push_back(reg_row(RegCoeff, 23'h020000));
    stim_table.push_back(item_row(ModeShake, 10'd0, 15'd0, 17'd65536));
    repeat (6) stim_table.push_back(item_row(ModeTick, 10'd0, 15'd0, 17'd0));
    stim_table.push_back(item_row(ModeTick, 10'h3ff, 15'h7fff, 17'd0));
    // Zero decays empty the energy and the level; after a clear the next tick is silent.
    stim_table.push_back(reg_row(RegCoeff, 23'h01ffff));
    stim_table.push_back(reg_row(RegSysDecay, 23'd0));
    stim_table.push_back(reg_row(RegSndDecay, 23'd0));
    stim_table.push_back(item_row(ModeTick, 10'd0, 15'h7fff, 17'd0));
    stim_table.push_back(item_row(ModeClear, 10'd0, 15'd0, 17'd0));
    stim_table.push_back(item_row(ModeTick, 10'd0, 15'd0, 17'd0, 1'b1, 32'd0));

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (stim_table[i]) begin
      if (stim_table[i].is_reg) begin
        drain_samples(QuietCycles);
        write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
      end else begin
        send_item(stim_table[i].mode, stim_table[i].draw, stim_table[i].noise,
                  stim_table[i].amount, stim_table[i].known, stim_table[i].want);
      end
    end

    // Random phases. The first uses the reset values, the second every register at its
    // top, the third every register at its bottom; the rest pick freely. Idling is switched
    // per phase so that some stretches run with no gaps or stalls, and the last phase
    // runs with none at all.
    for (int ph = 0; ph < NumPhases; ph++) begin
      style = (ph == 0) ? CfgNominal : (ph == 1) ? CfgHigh : (ph == 2) ? CfgLow : CfgRandom;
      drain_samples(QuietCycles);
      for (int r = int'(RegThreshold); r <= int'(RegSndDecay); r++) begin
        write_reg(3'(r), pick_reg_value(3'(r), style));
      end
      if ($urandom_range(0, 1) == 0) begin
        write_reg(3'($urandom_range(RegBadLow, RegBadHigh)), 23'($urandom()));
      end
      sender_gaps = (ph != NumPhases - 1) && (ph % 3 != 1);
      sink_stalls = (ph != NumPhases - 1) && (ph % 3 != 2);
      for (int n = 0; n < PhaseItems; n++) begin
        // Halfway through, the sender waits for every owed sample before going on.
        if (n == PhaseItems / 2) drain_samples(0);
        // Mostly ticks, with shakes often enough to keep energy in the system.
        pick = $urandom_range(0, 99);
        if (n == 0 || pick < 15) begin
          mode = ModeShake;
        end else if (pick < 85) begin
          mode = ModeTick;
        end else if (pick < 93) begin
          mode = ModeClear;
        end else begin
          mode = ModeSpare;
        end
        amount = ($urandom_range(0, 1) == 0) ? 17'($urandom_range(0, 131071))
                                             : 17'($urandom_range(0, 8000));
        send_item(mode, 10'($urandom_range(0, 1023)), 15'($urandom_range(0, 32767)), amount);
      end
    end

    drain_samples(TailCycles);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
